### hw/rtl/rgbdc_pkg.sv
package rgbdc_pkg;

	typedef enum logic [1:0] {
		CLASS_NONE  = 2'd0,
		CLASS_RED   = 2'd1,
		CLASS_GREEN = 2'd2,
		CLASS_BLUE  = 2'd3
	} cls_t;

	typedef enum logic [7:0] {
		REG_COLOR_MARGIN = 8'd0,
		REG_MARGIN_MODE  = 8'd1
	} reg_idx_t;

	localparam logic [7:0] MARGIN_RESET = 8'd30;
	localparam logic       MODE_RESET   = 1'b1;
	localparam logic [7:0] TALLY_MAX    = 8'hFF;

	typedef struct packed {
		logic [7:0] margin;
		logic       mode;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} tally_t;

endpackage

### hw/rtl/rgbdc_if.sv
interface rgbdc_pix_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_word;
	logic        end_of_line;

	modport source (output valid, output pixel_word, output end_of_line, input ready);
	modport sink (input valid, input pixel_word, input end_of_line, output ready);
endinterface

interface rgbdc_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] pixel_class;
	logic       line_done;
	logic [1:0] line_class;
	logic [7:0] red_total;
	logic [7:0] green_total;
	logic [7:0] blue_total;

	modport source (output valid, output pixel_class, output line_done, output line_class,
		output red_total, output green_total, output blue_total, input ready);
	modport sink (input valid, input pixel_class, input line_done, input line_class,
		input red_total, input green_total, input blue_total, output ready);
endinterface

interface rgbdc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/rgb565_dominant_color_counter.sv
// A pixel word accepted into the input register passes on to the
// pixel-class register and then to the result register.
// Throughput: one pixel word per cycle while results are taken; per-stage
// ready fills bubbles in the three-register pipeline while a result waits.
// Reset (arst_n low, async): all stages empty, line tallies zero,
// color_margin = 30, margin_mode = 1. Config writes are always ready.
module rgb565_dominant_color_counter
	import rgbdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rgbdc_cfg_if.sink   cfg,
	rgbdc_pix_if.sink   pix,
	rgbdc_res_if.source res
);

	cfg_t cfg_q;

	logic        v_s1;
	logic [15:0] pixel_s1;
	logic        eol_s1;

	logic v_s2;
	cls_t cls_s2;
	logic eol_s2;

	logic   v_out_q;
	logic   adv_s1, adv_s2, out_free;
	cls_t   pix_cls, line_cls;
	tally_t tally_nxt;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.margin <= MARGIN_RESET;
			cfg_q.mode   <= MODE_RESET;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_COLOR_MARGIN: cfg_q.margin <= cfg.data;
				REG_MARGIN_MODE:  cfg_q.mode   <= cfg.data[0];
				default:          cfg_q        <= cfg_q;
			endcase
		end
	end

	assign out_free  = !v_out_q || res.ready;
	assign adv_s2    = v_s2 && out_free;
	assign adv_s1    = v_s1 && (!v_s2 || out_free);
	assign pix.ready = !v_s1 || !v_s2 || out_free;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pix.ready) begin
			v_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			pixel_s1 <= pix.pixel_word;
			eol_s1   <= pix.end_of_line;
		end
	end

	// unpack without bit replication
	rgbdc_classify u_pix_cls (
		.cfg (cfg_q),
		.r   ({pixel_s1[15:11], 3'b000}),
		.g   ({pixel_s1[10:5], 2'b00}),
		.b   ({pixel_s1[4:0], 3'b000}),
		.cls (pix_cls)
	);

	// stage 2: pixel class
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || out_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cls_s2 <= pix_cls;
			eol_s2 <= eol_s1;
		end
	end

	rgbdc_tally u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv_s2),
		.cls       (cls_s2),
		.eol       (eol_s2),
		.tally_nxt (tally_nxt)
	);

	rgbdc_classify u_line_cls (
		.cfg (cfg_q),
		.r   (tally_nxt.red),
		.g   (tally_nxt.green),
		.b   (tally_nxt.blue),
		.cls (line_cls)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (out_free) begin
			v_out_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res.pixel_class <= cls_s2;
			res.line_done   <= eol_s2;
			res.line_class  <= eol_s2 ? line_cls : CLASS_NONE;
			res.red_total   <= eol_s2 ? tally_nxt.red : 8'd0;
			res.green_total <= eol_s2 ? tally_nxt.green : 8'd0;
			res.blue_total  <= eol_s2 ? tally_nxt.blue : 8'd0;
		end
	end

	assign res.valid = v_out_q;

`ifndef NO_ASSERTIONS
	a_sum_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.line_done |-> res.line_class == CLASS_NONE
			&& res.red_total == 8'd0 && res.green_total == 8'd0
			&& res.blue_total == 8'd0)
		else $error("line summary set on a mid-line word");
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready |=> v_s1)
		else $error("accepted word lost at stage 1");
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_free |=> v_s2 && $stable(cls_s2) && $stable(eol_s2))
		else $error("stage 2 word changed while stalled");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> res.valid)
		else $error("advancing word did not reach result register");
`endif

endmodule

### hw/rtl/rgbdc_classify.sv
module rgbdc_classify
	import rgbdc_pkg::*;
(
	input  cfg_t       cfg,
	input  logic [7:0] r,
	input  logic [7:0] g,
	input  logic [7:0] b,
	output cls_t       cls
);

	logic [8:0] r_w, g_w, b_w;
	logic [8:0] r_m, g_m, b_m;
	logic       r_win, g_win, b_win;

	assign r_w = {1'b0, r};
	assign g_w = {1'b0, g};
	assign b_w = {1'b0, b};

	// plain mode is the margin rule with a zero margin
	always_comb begin
		logic [8:0] m;
		m   = cfg.mode ? {1'b0, cfg.margin} : 9'd0;
		r_m = r_w + m;
		g_m = g_w + m;
		b_m = b_w + m;
	end

	assign r_win = (r_w > g_m) && (r_w > b_m);
	assign g_win = (g_w > r_m) && (g_w > b_m);
	assign b_win = (b_w > r_m) && (b_w > g_m);

	always_comb begin
		if (r_win) begin
			cls = CLASS_RED;
		end else if (g_win) begin
			cls = CLASS_GREEN;
		end else if (b_win) begin
			cls = CLASS_BLUE;
		end else begin
			cls = CLASS_NONE;
		end
	end

endmodule

### hw/rtl/rgbdc_tally.sv
module rgbdc_tally
	import rgbdc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  cls_t   cls,
	input  logic   eol,
	output tally_t tally_nxt
);

	tally_t tally_q;

	function automatic logic [7:0] bump(input logic [7:0] t);
		return (t == TALLY_MAX) ? TALLY_MAX : t + 8'd1;
	endfunction

	always_comb begin
		tally_nxt = tally_q;
		case (cls)
			CLASS_RED:   tally_nxt.red   = bump(tally_q.red);
			CLASS_GREEN: tally_nxt.green = bump(tally_q.green);
			CLASS_BLUE:  tally_nxt.blue  = bump(tally_q.blue);
			default:     tally_nxt = tally_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
		end else if (en) begin
			tally_q <= eol ? tally_t'('0) : tally_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	// a line end always leaves the counters empty
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		en && eol |=> tally_q == tally_t'('0))
		else $error("tally not cleared after line end");
	// counters never move without an advancing word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(tally_q))
		else $error("tally changed while stalled");
	// saturated red counter stays at max within the line
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		en && !eol && tally_q.red == TALLY_MAX |=> tally_q.red == TALLY_MAX)
		else $error("red tally left saturation");
`endif

endmodule
